// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/rapq_pkg.sv =====
`timescale 1ns / 1ps

package rapq_pkg;

  localparam int unsigned MaxLeaves = 1024;
  localparam int unsigned NodeCount = 2 * MaxLeaves;
  localparam int unsigned LeafAw    = $clog2(MaxLeaves);
  localparam int unsigned NodeAw    = $clog2(NodeCount);
  localparam int unsigned SizeW     = LeafAw + 1;
  localparam int unsigned RangeW    = NodeAw + 1;
  localparam int unsigned LvlW      = $clog2(NodeAw);
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 3;

  localparam logic RegUsedSize = 1'b0;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_RANGE = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QSETUP,
    ST_QNODE,
    ST_QSIB,
    ST_QLAST,
    ST_QWAIT,
    ST_QOUT,
    ST_RANGE
  } state_e;

  typedef enum logic [1:0] {
    KIND_CLR,
    KIND_SIB,
    KIND_RNG
  } kind_e;

  typedef struct packed {
    func_e             func;
    logic [LeafAw-1:0] index;
    logic [LeafAw-1:0] range_start;
    logic [SizeW-1:0]  range_end;
    logic [DataW-1:0]  amount;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] value;
  } res_t;

endpackage

// ===== hdl/rapq_ram.sv =====
`timescale 1ns / 1ps

module rapq_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rapq_regs.sv =====
`timescale 1ns / 1ps

module rapq_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rapq_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [rapq_pkg::SizeW-1:0]  n_eff_o
);

  logic [rapq_pkg::SizeW-1:0] used_size_q, used_size_d;
  logic                       sel_used;

  assign sel_used = (paddr[rapq_pkg::AddrW-1] == rapq_pkg::RegUsedSize);

  always_comb begin
    used_size_d = used_size_q;
    if (psel && penable && pwrite && sel_used) begin
      used_size_d = pwdata[rapq_pkg::SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_size_q <= rapq_pkg::SizeW'(rapq_pkg::MaxLeaves);
    end else begin
      used_size_q <= used_size_d;
    end
  end

  // zero acts as one, oversize acts as full tree
  always_comb begin
    n_eff_o = used_size_q;
    if (used_size_q == '0) begin
      n_eff_o = rapq_pkg::SizeW'(1);
    end else if (used_size_q > rapq_pkg::SizeW'(rapq_pkg::MaxLeaves)) begin
      n_eff_o = rapq_pkg::SizeW'(rapq_pkg::MaxLeaves);
    end
  end

  assign prdata = sel_used ? {{(32 - rapq_pkg::SizeW){1'b0}}, used_size_q} : 32'd0;
  assign pready = 1'b1;

endmodule

// ===== hdl/rapq_seq.sv =====
`timescale 1ns / 1ps

module rapq_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  rapq_pkg::cmd_t              cmd_i,
  input  logic [rapq_pkg::SizeW-1:0]  n_i,
  output logic                        busy_o,
  output rapq_pkg::res_t              res_o
);

  localparam int unsigned NodeAw = rapq_pkg::NodeAw;
  localparam int unsigned LeafAw = rapq_pkg::LeafAw;
  localparam int unsigned RangeW = rapq_pkg::RangeW;
  localparam int unsigned LvlW   = rapq_pkg::LvlW;
  localparam int unsigned DataW  = rapq_pkg::DataW;

  rapq_pkg::state_e state_q, state_d;

  logic [NodeAw-1:0] clr_cnt_q, clr_cnt_d;
  logic              proc_valid_q, proc_valid_d;
  logic              res_valid_q, res_valid_d;
  logic              hi_pend_q, hi_pend_d;

  rapq_pkg::kind_e   proc_kind_q, proc_kind_d;
  logic [NodeAw-1:0] proc_addr_q, proc_addr_d;
  logic [LeafAw-1:0] pos_q, pos_d;
  logic [NodeAw-1:0] leaf_q, leaf_d;
  logic [LvlW-1:0]   lvl_q, lvl_d;
  logic [DataW-1:0]  amt_q, amt_d;
  logic [DataW-1:0]  acc_q, acc_d;
  logic [RangeW-1:0] lo_q, lo_d;
  logic [RangeW-1:0] hi_q, hi_d;
  logic [DataW-1:0]  res_value_q, res_value_d;

  logic              accept;
  logic              idx_ok;
  logic [LvlW-1:0]   top_lvl;
  logic [RangeW-1:0] lo_p1;
  logic [RangeW-1:0] hi_m1;
  logic [rapq_pkg::SizeW-1:0] rend_c;

  logic [DataW-1:0]  add_a, add_b, sum;

  logic              pend_we, pend_re;
  logic [NodeAw-1:0] pend_waddr, pend_raddr;
  logic [DataW-1:0]  pend_wdata, pend_rdata;
  rapq_pkg::kind_e   rd_kind;

  logic              leaf_we, leaf_re;
  logic [LeafAw-1:0] leaf_waddr;
  logic [DataW-1:0]  leaf_wdata, leaf_rdata;

  assign accept = start_i && (state_q == rapq_pkg::ST_IDLE);
  assign idx_ok = ({1'b0, cmd_i.index} < n_i);
  assign lo_p1  = lo_q + RangeW'(1);
  assign hi_m1  = hi_q - RangeW'(1);
  assign rend_c = (cmd_i.range_end > n_i) ? n_i : cmd_i.range_end;

  // depth of the queried leaf
  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < NodeAw; i++) begin
      if (leaf_q[i]) begin
        top_lvl = LvlW'(i);
      end
    end
  end

  // shared adder
  always_comb begin
    add_a = (state_q == rapq_pkg::ST_QOUT) ? leaf_rdata : pend_rdata;
    add_b = ((state_q == rapq_pkg::ST_QOUT) || (proc_kind_q != rapq_pkg::KIND_RNG)) ?
            acc_q : amt_q;
    sum   = add_a + add_b;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rapq_pkg::ST_CLEAR: begin
        if (clr_cnt_q == NodeAw'(rapq_pkg::NodeCount - 1)) begin
          state_d = rapq_pkg::ST_IDLE;
        end
      end
      rapq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i.func)
            rapq_pkg::FUNC_QUERY: begin
              if (idx_ok) begin
                state_d = rapq_pkg::ST_QSETUP;
              end
            end
            rapq_pkg::FUNC_RANGE: state_d = rapq_pkg::ST_RANGE;
            default:              state_d = rapq_pkg::ST_IDLE;
          endcase
        end
      end
      rapq_pkg::ST_QSETUP: begin
        state_d = (top_lvl == '0) ? rapq_pkg::ST_QLAST : rapq_pkg::ST_QNODE;
      end
      rapq_pkg::ST_QNODE: state_d = rapq_pkg::ST_QSIB;
      rapq_pkg::ST_QSIB: begin
        state_d = (lvl_q == LvlW'(1)) ? rapq_pkg::ST_QLAST : rapq_pkg::ST_QNODE;
      end
      rapq_pkg::ST_QLAST: state_d = rapq_pkg::ST_QWAIT;
      rapq_pkg::ST_QWAIT: state_d = rapq_pkg::ST_QOUT;
      rapq_pkg::ST_QOUT:  state_d = rapq_pkg::ST_IDLE;
      rapq_pkg::ST_RANGE: begin
        if (!hi_pend_q && (lo_q >= hi_q)) begin
          state_d = rapq_pkg::ST_IDLE;
        end
      end
      default: state_d = rapq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    clr_cnt_d   = clr_cnt_q;
    hi_pend_d   = hi_pend_q;
    pos_d       = pos_q;
    leaf_d      = leaf_q;
    lvl_d       = lvl_q;
    amt_d       = amt_q;
    acc_d       = acc_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pend_re     = 1'b0;
    pend_raddr  = leaf_q;
    rd_kind     = rapq_pkg::KIND_CLR;
    leaf_re     = 1'b0;
    res_valid_d = 1'b0;
    res_value_d = '0;

    if (proc_valid_q && (proc_kind_q == rapq_pkg::KIND_CLR)) begin
      acc_d = sum;
    end

    unique case (state_q)
      rapq_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + NodeAw'(1);
      end
      rapq_pkg::ST_IDLE: begin
        if (accept) begin
          pos_d     = cmd_i.index;
          leaf_d    = NodeAw'({1'b0, cmd_i.index} + n_i);
          amt_d     = cmd_i.amount;
          acc_d     = '0;
          lo_d      = RangeW'(cmd_i.range_start) + RangeW'(n_i);
          hi_d      = RangeW'(rend_c) + RangeW'(n_i);
          hi_pend_d = 1'b0;
          if ((cmd_i.func == rapq_pkg::FUNC_QUERY) && !idx_ok) begin
            res_valid_d = 1'b1;
          end
        end
      end
      rapq_pkg::ST_QSETUP: begin
        lvl_d   = top_lvl;
        leaf_re = 1'b1;
      end
      rapq_pkg::ST_QNODE: begin
        pend_re    = 1'b1;
        pend_raddr = leaf_q >> lvl_q;
        rd_kind    = rapq_pkg::KIND_CLR;
      end
      rapq_pkg::ST_QSIB: begin
        pend_re    = 1'b1;
        pend_raddr = (leaf_q >> (lvl_q - LvlW'(1))) ^ NodeAw'(1);
        rd_kind    = rapq_pkg::KIND_SIB;
        lvl_d      = lvl_q - LvlW'(1);
      end
      rapq_pkg::ST_QLAST: begin
        pend_re    = 1'b1;
        pend_raddr = leaf_q;
        rd_kind    = rapq_pkg::KIND_CLR;
      end
      rapq_pkg::ST_QWAIT: begin
      end
      rapq_pkg::ST_QOUT: begin
        res_valid_d = 1'b1;
        res_value_d = sum;
      end
      rapq_pkg::ST_RANGE: begin
        rd_kind = rapq_pkg::KIND_RNG;
        if (hi_pend_q) begin
          pend_re    = 1'b1;
          pend_raddr = hi_m1[NodeAw-1:0];
          lo_d       = lo_q >> 1;
          hi_d       = hi_m1 >> 1;
          hi_pend_d  = 1'b0;
        end else if (lo_q < hi_q) begin
          priority if (lo_q[0]) begin
            pend_re    = 1'b1;
            pend_raddr = lo_q[NodeAw-1:0];
            if (hi_q[0]) begin
              lo_d      = lo_p1;
              hi_pend_d = 1'b1;
            end else begin
              lo_d = lo_p1 >> 1;
              hi_d = hi_q >> 1;
            end
          end else if (hi_q[0]) begin
            pend_re    = 1'b1;
            pend_raddr = hi_m1[NodeAw-1:0];
            lo_d       = lo_q >> 1;
            hi_d       = hi_m1 >> 1;
          end else begin
            lo_d = lo_q >> 1;
            hi_d = hi_q >> 1;
          end
        end
      end
      default: begin
      end
    endcase

    proc_valid_d = pend_re;
    proc_kind_d  = rd_kind;
    proc_addr_d  = pend_raddr;
  end

  // pending-add write-back in the cycle after each read; zero fill while clearing
  always_comb begin
    pend_we    = (state_q == rapq_pkg::ST_CLEAR) || proc_valid_q;
    pend_waddr = (state_q == rapq_pkg::ST_CLEAR) ? clr_cnt_q : proc_addr_q;
    pend_wdata = ((state_q == rapq_pkg::ST_CLEAR) || (proc_kind_q == rapq_pkg::KIND_CLR)) ?
                 '0 : sum;
  end

  always_comb begin
    leaf_we    = (accept && (cmd_i.func == rapq_pkg::FUNC_LOAD) && idx_ok) ||
                 (state_q == rapq_pkg::ST_QOUT);
    leaf_waddr = (state_q == rapq_pkg::ST_QOUT) ? pos_q : cmd_i.index;
    leaf_wdata = (state_q == rapq_pkg::ST_QOUT) ? sum : cmd_i.amount;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rapq_pkg::ST_CLEAR;
      clr_cnt_q    <= '0;
      proc_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      hi_pend_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      proc_valid_q <= proc_valid_d;
      res_valid_q  <= res_valid_d;
      hi_pend_q    <= hi_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_kind_q <= proc_kind_d;
    proc_addr_q <= proc_addr_d;
    pos_q       <= pos_d;
    leaf_q      <= leaf_d;
    lvl_q       <= lvl_d;
    amt_q       <= amt_d;
    acc_q       <= acc_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    res_value_q <= res_value_d;
  end

  rapq_ram #(
    .Depth(rapq_pkg::NodeCount),
    .Width(DataW)
  ) u_pend_ram (
    .clk_i  (clk_i),
    .we_i   (pend_we),
    .waddr_i(pend_waddr),
    .wdata_i(pend_wdata),
    .re_i   (pend_re),
    .raddr_i(pend_raddr),
    .rdata_o(pend_rdata)
  );

  rapq_ram #(
    .Depth(rapq_pkg::MaxLeaves),
    .Width(DataW)
  ) u_leaf_ram (
    .clk_i  (clk_i),
    .we_i   (leaf_we),
    .waddr_i(leaf_waddr),
    .wdata_i(leaf_wdata),
    .re_i   (leaf_re),
    .raddr_i(pos_q),
    .rdata_o(leaf_rdata)
  );

  assign busy_o      = (state_q != rapq_pkg::ST_IDLE);
  assign res_o.valid = res_valid_q;
  assign res_o.value = res_value_q;

endmodule

// ===== hdl/range_add_point_query_tree.sv =====
// channel   direction  handshake                        payload
// command   in         start & !busy                    func, index, range, amount
// result    out        point_valid_o, one cycle         point_value_o
// config    in         psel & penable & pwrite & pready used_size at byte 0
//
// load and out-of-range query do not raise busy; a query walks the path from the root
// to the leaf, reading the pending adds on it and of their siblings, each written back in the following cycle
// a range add climbs the tree level by level from the leaves, adding the amount
// to the pending add of each node that either end of the range selects
// after reset a clearing pass zeroes every pending add while busy is high
// results are strobed for one cycle and cannot be stalled
`timescale 1ns / 1ps
`include "assert_macros.svh"

module range_add_point_query_tree (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          func_i,
  input  logic [rapq_pkg::LeafAw-1:0]         index_i,
  input  logic [rapq_pkg::LeafAw-1:0]         range_start_i,
  input  logic [rapq_pkg::SizeW-1:0]          range_end_i,
  input  logic signed [rapq_pkg::DataW-1:0]   amount_i,
  output logic                                point_valid_o,
  output logic signed [rapq_pkg::DataW-1:0]   point_value_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rapq_pkg::AddrW-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  rapq_pkg::cmd_t             cmd;
  rapq_pkg::res_t             res;
  logic [rapq_pkg::SizeW-1:0] n_eff;
  logic                       cmd_accept;
  logic                       nonquery_acc;
  logic                       query_oob;

  always_comb begin
    cmd.func        = rapq_pkg::func_e'(func_i);
    cmd.index       = index_i;
    cmd.range_start = range_start_i;
    cmd.range_end   = range_end_i;
    cmd.amount      = amount_i;
  end

  rapq_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .n_eff_o(n_eff)
  );

  rapq_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .cmd_i  (cmd),
    .n_i    (n_eff),
    .busy_o (busy),
    .res_o  (res)
  );

  assign point_valid_o = res.valid;
  assign point_value_o = res.value;

  assign cmd_accept   = start && !busy;
  assign nonquery_acc = cmd_accept && (func_i != rapq_pkg::FUNC_QUERY);
  assign query_oob    = cmd_accept && (func_i == rapq_pkg::FUNC_QUERY) &&
                        ({1'b0, index_i} >= n_eff);

  `ASSERT_IMPL(a_strobe_when_idle, clk_i, rst_ni, point_valid_o, !busy)
  `ASSERT_NEXT(a_no_strobe_non_query, clk_i, rst_ni, nonquery_acc, !point_valid_o)
  `ASSERT_NEXT(a_oob_query_zero, clk_i, rst_ni, query_oob, point_valid_o && (point_value_o == 0))

endmodule
